[hdl/ptlt_pkg.sv]
// ----------------------------------------------------------------------------
// ptlt_pkg
// Shared types and constants of the ping timeout and loss tracker.
// ----------------------------------------------------------------------------
package ptlt_pkg;

  localparam int MODE_W    = 3;
  localparam int PORT_W    = 4;
  localparam int LOSS_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_PING  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PONG  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LIST  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd1;

  typedef struct packed {
    logic              ping;
    logic              pong;
    logic              tick;
    logic              query;
    logic              scan_step;
    logic              list_step;
    logic              list_end;
    logic              in_range;
    logic [PORT_W-1:0] port;
  } cmd_t;

endpackage

[hdl/ptlt_ctrl.sv]
// ----------------------------------------------------------------------------
// ptlt_ctrl
// Sequencer: decodes items and sweeps the port index for scan and list.
// ----------------------------------------------------------------------------
module ptlt_ctrl #(
  parameter int NUM_PORTS = 16,
  parameter int AW        = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ptlt_pkg::MODE_W-1:0] mode_i,
  input  logic [ptlt_pkg::PORT_W-1:0] port_i,
  output logic                       busy_o,
  output ptlt_pkg::cmd_t             cmd_o,
  output logic [AW-1:0]              addr_o
);
  import ptlt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;
  localparam logic [1:0] S_LEND = 2'd3;

  localparam logic [AW-1:0] CNT_LAST = AW'(NUM_PORTS - 1);

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [6:0]    port_ext;
  logic          accept;

  assign port_ext = 7'(port_i);
  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.port     = port_i;
    cmd_o.in_range = (port_ext < 7'(NUM_PORTS));
    addr_o  = port_ext[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_PING:  cmd_o.ping  = 1'b1;
            MODE_PONG:  cmd_o.pong  = 1'b1;
            MODE_TICK:  cmd_o.tick  = 1'b1;
            MODE_QUERY: cmd_o.query = 1'b1;
            MODE_SCAN: begin
              state_d = S_SCAN;
              cnt_d   = '0;
            end
            MODE_LIST: begin
              state_d = S_LIST;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        addr_o          = cnt_q;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        cmd_o.list_step = 1'b1;
        addr_o          = cnt_q;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_LEND;
        end
      end
      S_LEND: begin
        cmd_o.list_end = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[hdl/ptlt_datapath.sv]
// ----------------------------------------------------------------------------
// ptlt_datapath
// Per-port stamp, wait, seen and loss storage, timer, config and result regs.
// ----------------------------------------------------------------------------
module ptlt_datapath #(
  parameter int NUM_PORTS  = 16,
  parameter int TIME_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptlt_pkg::cmd_t                cmd_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic                          cfg_we_i,
  input  logic [ptlt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptlt_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [ptlt_pkg::PORT_W-1:0]   port_out_o,
  output logic                          port_valid_o,
  output logic [ptlt_pkg::LOSS_W-1:0]   loss_total_o,
  output logic                          last_o
);
  import ptlt_pkg::*;

  logic [TIME_WIDTH-1:0] time_q;
  logic [TIME_WIDTH-1:0] stamp_q [NUM_PORTS];
  logic [NUM_PORTS-1:0]  wait_q;
  logic [NUM_PORTS-1:0]  seen_q;
  logic [LOSS_W-1:0]     lost_q  [NUM_PORTS];
  logic [CFG_W-1:0]      tmo_q, thr_q;

  logic                  res_q;
  logic [PORT_W-1:0]     port_q;
  logic                  pvalid_q;
  logic [LOSS_W-1:0]     loss_q;
  logic                  last_q;

  logic                  pend_q;
  logic [PORT_W-1:0]     pend_port_q;
  logic [LOSS_W-1:0]     pend_loss_q;

  logic                  seen_r, wait_r;
  logic [LOSS_W-1:0]     lost_r;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired, qualify;

  assign seen_r  = seen_q[addr_i];
  assign wait_r  = wait_q[addr_i];
  assign lost_r  = lost_q[addr_i];
  assign elapsed = time_q - stamp_q[addr_i];
  assign expired = seen_r && wait_r && (elapsed > TIME_WIDTH'(tmo_q));
  assign qualify = seen_r && (lost_r >= thr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ping && cmd_i.in_range) begin
      stamp_q[addr_i] <= time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      wait_q <= '0;
      seen_q <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        lost_q[i] <= '0;
      end
      tmo_q  <= TIMEOUT_RST;
      thr_q  <= THRESHOLD_RST;
      pend_q <= 1'b0;
      res_q  <= 1'b0;
    end else begin
      res_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:   tmo_q <= cfg_wdata_i;
          CFG_THRESHOLD: thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        time_q <= time_q + 1'b1;
      end
      if (cmd_i.ping && cmd_i.in_range) begin
        wait_q[addr_i] <= 1'b1;
        seen_q[addr_i] <= 1'b1;
      end
      if (cmd_i.pong && cmd_i.in_range) begin
        wait_q[addr_i] <= 1'b0;
        seen_q[addr_i] <= 1'b1;
      end
      if (cmd_i.scan_step && expired) begin
        wait_q[addr_i] <= 1'b0;
        if (lost_r != '1) begin
          lost_q[addr_i] <= lost_r + 1'b1;
        end
      end
      if (cmd_i.query) begin
        res_q <= 1'b1;
      end
      if (cmd_i.list_step && qualify) begin
        pend_q <= 1'b1;
        if (pend_q) begin
          res_q <= 1'b1;
        end
      end
      if (cmd_i.list_end) begin
        pend_q <= 1'b0;
        res_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      port_q   <= cmd_i.port;
      pvalid_q <= 1'b1;
      loss_q   <= (cmd_i.in_range && seen_r) ? lost_r : '0;
      last_q   <= 1'b1;
    end
    if (cmd_i.list_step && qualify) begin
      pend_port_q <= PORT_W'(addr_i);
      pend_loss_q <= lost_r;
      port_q      <= pend_port_q;
      pvalid_q    <= 1'b1;
      loss_q      <= pend_loss_q;
      last_q      <= 1'b0;
    end
    if (cmd_i.list_end) begin
      port_q   <= pend_q ? pend_port_q : '0;
      pvalid_q <= pend_q;
      loss_q   <= pend_q ? pend_loss_q : '0;
      last_q   <= 1'b1;
    end
  end

  assign result_valid_o = res_q;
  assign port_out_o     = port_q;
  assign port_valid_o   = pvalid_q;
  assign loss_total_o   = loss_q;
  assign last_o         = last_q;

endmodule

[hdl/ping_timeout_loss_tracker_top.sv]
// ----------------------------------------------------------------------------
// ping_timeout_loss_tracker_top
// Per-port ping liveness tracker with timeout scan, loss query and listing.
// Ping, pong and tick never raise busy; a query result strobes the next cycle.
// Scan keeps busy high while it steps through the ports, one port per cycle.
// List keeps busy high over its port steps and an end step; each listed port strobes once
// the next is found, the final result in the cycle in which busy falls.
// Results cannot be stalled. Reset clears timer, waits, seen flags, counts.
// ----------------------------------------------------------------------------
module ping_timeout_loss_tracker_top #(
  parameter int NUM_PORTS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ptlt_pkg::MODE_W-1:0]    mode_i,
  input  logic [ptlt_pkg::PORT_W-1:0]    port_i,
  input  logic                           cfg_we_i,
  input  logic [ptlt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptlt_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [ptlt_pkg::PORT_W-1:0]    port_out_o,
  output logic                           port_valid_o,
  output logic [ptlt_pkg::LOSS_W-1:0]    loss_total_o,
  output logic                           last_o
);
  import ptlt_pkg::*;

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  cmd_t          cmd;
  logic [AW-1:0] addr;

  ptlt_ctrl #(
    .NUM_PORTS(NUM_PORTS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (mode_i),
    .port_i (port_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .addr_o (addr)
  );

  ptlt_datapath #(
    .NUM_PORTS (NUM_PORTS),
    .TIME_WIDTH(TIME_WIDTH),
    .AW        (AW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .port_out_o    (port_out_o),
    .port_valid_o  (port_valid_o),
    .loss_total_o  (loss_total_o),
    .last_o        (last_o)
  );

endmodule

[hdl/ptlt_checker.sv]
// ----------------------------------------------------------------------------
// ptlt_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ptlt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [ptlt_pkg::MODE_W-1:0]    mode_i,
  input logic [ptlt_pkg::PORT_W-1:0]    port_i,
  input logic                           result_valid_o,
  input logic [ptlt_pkg::PORT_W-1:0]    port_out_o,
  input logic                           port_valid_o,
  input logic [ptlt_pkg::LOSS_W-1:0]    loss_total_o,
  input logic                           last_o
);
  import ptlt_pkg::*;

  logic xfer;
  assign xfer = start_i && !busy_o;

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (mode_i == MODE_QUERY) |=> result_valid_o && port_valid_o && last_o
      && (port_out_o == $past(port_i)))
    else $error("query transfer did not give a single result");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && ((mode_i == MODE_SCAN) || (mode_i == MODE_LIST)) |=> busy_o)
    else $error("sweep did not hold busy");

  a_quiet_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && ((mode_i == MODE_PING) || (mode_i == MODE_PONG) || (mode_i == MODE_TICK))
      |=> !result_valid_o && !busy_o)
    else $error("ping, pong or tick caused a result or stayed busy");

  a_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !port_valid_o |-> last_o && (loss_total_o == '0)
      && (port_out_o == '0))
    else $error("empty list result malformed");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("non-final result outside a list sweep");

endmodule

bind ping_timeout_loss_tracker_top ptlt_checker u_ptlt_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ping timeout and loss tracker. A queue of
// commands feeds a clocked driver on the start/busy handshake; a shadow copy
// of the port table predicts every query and list report, and a clocked
// monitor compares each report strobe field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import ptlt_pkg::*;

  localparam int NUM_PORTS  = 16;
  localparam int TIME_WIDTH = 32;

  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [PORT_W-1:0] port;
    bit                hold;
    bit                steady;
  } ping_cmd_t;

  typedef struct {
    logic [PORT_W-1:0] port;
    logic              pvalid;
    logic [LOSS_W-1:0] loss;
    logic              fin;
  } loss_report_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  logic [MODE_W-1:0]    mode_i      = '0;
  logic [PORT_W-1:0]    port_i      = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 result_valid_o;
  logic [PORT_W-1:0]    port_out_o;
  logic                 port_valid_o;
  logic [LOSS_W-1:0]    loss_total_o;
  logic                 last_o;

  ping_cmd_t    cmd_backlog[$];
  loss_report_t reports_due[$];
  loss_report_t due;

  logic [TIME_WIDTH-1:0] clock_ms;
  logic [TIME_WIDTH-1:0] stamp_q[NUM_PORTS];
  bit                    waiting_q[NUM_PORTS];
  bit                    seen_q[NUM_PORTS];
  logic [LOSS_W-1:0]     losses_q[NUM_PORTS];
  logic [CFG_W-1:0]      timeout_r;
  logic [CFG_W-1:0]      threshold_r;

  int n_errors;
  int n_sent;
  int n_reports;
  int n_lost;
  int n_settings;

  ping_timeout_loss_tracker_top #(
    .NUM_PORTS (NUM_PORTS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .port_i        (port_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .port_out_o    (port_out_o),
    .port_valid_o  (port_valid_o),
    .loss_total_o  (loss_total_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void add_report(loss_report_t r);
    reports_due.insert(reports_due.size(), r);
  endfunction

  function automatic void add_cmd(ping_cmd_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // Advance the shadow port table by one command and queue its reports.
  function automatic void track_command(logic [MODE_W-1:0] op, logic [PORT_W-1:0] p);
    int                    i;
    int                    listed;
    logic [TIME_WIDTH-1:0] elapsed;
    loss_report_t          r;
    listed = 0;
    case (op)
      MODE_PING: begin
        stamp_q[p]   = clock_ms;
        waiting_q[p] = 1'b1;
        seen_q[p]    = 1'b1;
      end
      MODE_PONG: begin
        waiting_q[p] = 1'b0;
        seen_q[p]    = 1'b1;
      end
      MODE_TICK: clock_ms = clock_ms + 1'b1;
      MODE_SCAN: begin
        for (i = 0; i < NUM_PORTS; i++) begin
          elapsed = clock_ms - stamp_q[i];
          if (seen_q[i] && waiting_q[i] && elapsed > {16'd0, timeout_r}) begin
            if (losses_q[i] != '1) losses_q[i] = losses_q[i] + 1'b1;
            waiting_q[i] = 1'b0;
            n_lost++;
          end
        end
      end
      MODE_QUERY: begin
        r.port   = p;
        r.pvalid = 1'b1;
        r.loss   = seen_q[p] ? losses_q[p] : '0;
        r.fin    = 1'b1;
        add_report(r);
      end
      MODE_LIST: begin
        for (i = 0; i < NUM_PORTS; i++) begin
          if (seen_q[i] && losses_q[i] >= threshold_r) begin
            r.port   = i[PORT_W-1:0];
            r.pvalid = 1'b1;
            r.loss   = losses_q[i];
            r.fin    = 1'b0;
            add_report(r);
            listed++;
          end
        end
        if (listed == 0) begin
          r.port   = '0;
          r.pvalid = 1'b0;
          r.loss   = '0;
          r.fin    = 1'b1;
          add_report(r);
        end else begin
          reports_due[reports_due.size()-1].fin = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic ping_cmd_t random_cmd();
    ping_cmd_t c;
    int        roll;
    roll     = $urandom_range(99);
    c.port   = $urandom_range(15);
    c.hold   = 1'b0;
    c.steady = 1'b0;
    if (roll < 20)      c.op = MODE_PING;
    else if (roll < 30) c.op = MODE_PONG;
    else if (roll < 55) c.op = MODE_TICK;
    else if (roll < 70) c.op = MODE_SCAN;
    else if (roll < 84) c.op = MODE_QUERY;
    else if (roll < 95) c.op = MODE_LIST;
    else if (roll < 98) c.op = MODE_SPARE6;
    else                c.op = MODE_SPARE7;
    return c;
  endfunction

  task automatic queue_cmd(logic [MODE_W-1:0] op, logic [PORT_W-1:0] p);
    ping_cmd_t c;
    c.op     = op;
    c.port   = p;
    c.hold   = 1'b0;
    c.steady = 1'b0;
    add_cmd(c);
  endtask

  // Hold until every command is accepted and every report is in, then let a
  // full port sweep run out.
  task automatic settle();
    while (cmd_backlog.size() != 0 || reports_due.size() != 0) @(negedge clk_i);
    repeat (NUM_PORTS + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_r = val;
    else                    threshold_r = val;
    n_settings++;
  endtask

  task automatic compare_field(string fname, logic [LOSS_W-1:0] want_v,
                               logic [LOSS_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, fname, want_v, got_v);
      n_errors++;
    end
  endtask

  // Driver: retire the accepted command, then offer the next or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        track_command(mode_i, port_i);
        void'(cmd_backlog.pop_front());
        n_sent++;
      end
      if (cmd_backlog.size() != 0 && !(cmd_backlog[0].hold && reports_due.size() != 0) &&
          (cmd_backlog[0].steady || $urandom_range(99) >= 27)) begin
        start_i <= 1'b1;
        mode_i  <= cmd_backlog[0].op;
        port_i  <= cmd_backlog[0].port;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every report transfer must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      n_reports++;
      if (reports_due.size() == 0) begin
        $display("%0t ns: unexpected report, expected none actual port %0d loss %0d",
                 $time, port_out_o, loss_total_o);
        n_errors++;
      end else begin
        due = reports_due.pop_front();
        compare_field("port_out", {12'd0, due.port}, {12'd0, port_out_o});
        compare_field("port_valid", {15'd0, due.pvalid}, {15'd0, port_valid_o});
        compare_field("loss_total", due.loss, loss_total_o);
        compare_field("last", {15'd0, due.fin}, {15'd0, last_o});
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_timeout[5];
    logic [CFG_W-1:0] phase_threshold[5];
    ping_cmd_t        c;
    int               ph;
    int               k;

    phase_timeout   = '{16'hFFFF, 16'd1, 16'd3, 16'd0, 16'd2};
    phase_threshold = '{16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd3};
    clock_ms    = '0;
    timeout_r   = TIMEOUT_RST;
    threshold_r = THRESHOLD_RST;
    for (k = 0; k < NUM_PORTS; k++) begin
      stamp_q[k]   = '0;
      waiting_q[k] = 1'b0;
      seen_q[k]    = 1'b0;
      losses_q[k]  = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: empty lists, unseen ports, spare modes, pong on a fresh port.
    queue_cmd(MODE_LIST, 4'd0);
    queue_cmd(MODE_QUERY, 4'd0);
    queue_cmd(MODE_QUERY, 4'd15);
    queue_cmd(MODE_SPARE6, 4'd3);
    queue_cmd(MODE_SPARE7, 4'd12);
    queue_cmd(MODE_PONG, 4'd5);
    queue_cmd(MODE_PING, 4'd15);
    queue_cmd(MODE_SCAN, 4'd0);
    queue_cmd(MODE_QUERY, 4'd5);
    queue_cmd(MODE_LIST, 4'd0);
    settle();

    // Zero timeout and zero threshold: expiry needs one tick, every seen port listed.
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd0);
    @(negedge clk_i);
    queue_cmd(MODE_PING, 4'd0);
    queue_cmd(MODE_PING, 4'd15);
    queue_cmd(MODE_TICK, 4'd7);
    queue_cmd(MODE_PING, 4'd9);
    queue_cmd(MODE_SCAN, 4'd0);
    queue_cmd(MODE_QUERY, 4'd0);
    queue_cmd(MODE_QUERY, 4'd15);
    queue_cmd(MODE_QUERY, 4'd9);
    queue_cmd(MODE_LIST, 4'd0);
    queue_cmd(MODE_PONG, 4'd9);
    queue_cmd(MODE_PONG, 4'd3);
    queue_cmd(MODE_LIST, 4'd0);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TIMEOUT, phase_timeout[ph]);
      write_reg(CFG_THRESHOLD, phase_threshold[ph]);
      @(negedge clk_i);
      for (k = 0; k < 62; k++) begin
        c        = random_cmd();
        c.hold   = (k == 30);
        c.steady = (ph == 2 && k < 50);
        add_cmd(c);
      end
      settle();
    end

    $display("Covered %0d commands and %0d report transfers under %0d register writes;",
             n_sent, n_reports, n_settings);
    $display("%0d pings timed out across all ports.", n_lost);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
